@@ hdl/sjrg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sjrg_pkg
// shared types and constants of the servo joint ramp generator
// ----------------------------------------------------------------------------
package sjrg_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam int ANGLE_W = 8;
    localparam int PULSE_W = 12;
    localparam int CH_W    = 4;
    localparam int DUR_W   = 16;
    localparam int DIV_N_W = 24;
    localparam int DIV_D_W = 16;
    localparam int DIV_C_W = 5;
    localparam int RECIP_W = 19;

    localparam logic [DIV_C_W-1:0] DIV_STEPS   = 5'd24;
    localparam logic [PULSE_W-1:0] PULSE_TOP   = 12'd4095;
    localparam logic [ANGLE_W-1:0] RESET_ANGLE = 8'd90;
    localparam logic [DUR_W-1:0]   ELAPSED_TOP = 16'hFFFF;
    // ceil(2**24 / 45), exact for 18-bit values; a quarter of it divides by 180
    localparam logic [RECIP_W-1:0] PULSE_RECIP = 19'd372828;

    typedef struct packed {
        logic load;
        logic start;
        logic tick;
        logic pos_mul;
        logic pos_div;
        logic pos_wb;
        logic pul_mul;
        logic pul_div;
        logic emit_pulse;
        logic emit_done;
    } sjrg_cmd_t;

    typedef struct packed {
        logic done_cond;
        logic moving;
        logic div_done;
        logic sel_changed;
        logic sel_last;
        logic out_free;
    } sjrg_sts_t;

endpackage
`default_nettype wire

@@ hdl/servo_joint_ramp_generator_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// servo_joint_ramp_generator_unit
// timed linear servo ramp over JOINTS joints with per-joint pulse scaling
// sequence: a load item is taken in idle; a start, or a tick in a move, goes
// to the end check, which emits a done result or has the positions set by the
// 24-step serial divider joint by joint, then emits a pulse for each changed
// joint, waiting on output stalls; one item in work at a time, next accepted
// on return to idle even while the last result waits in the output register
// reset: joint settings zero, angles 90 degrees, timer zero, move idle
// ----------------------------------------------------------------------------
module servo_joint_ramp_generator_unit
#(
    parameter int JOINTS = 3
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    operation,
    input  wire logic [1:0]                    joint,
    input  wire logic [sjrg_pkg::CH_W-1:0]     channel,
    input  wire logic [sjrg_pkg::ANGLE_W-1:0]  target_angle,
    input  wire logic [sjrg_pkg::PULSE_W-1:0]  pulse_min,
    input  wire logic [sjrg_pkg::PULSE_W-1:0]  pulse_max,
    input  wire logic [sjrg_pkg::DUR_W-1:0]    duration_ms,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [sjrg_pkg::CH_W-1:0]     out_channel,
    output logic      [sjrg_pkg::PULSE_W-1:0]  pulse,
    output logic                               move_done,
    output logic                               last
);

    localparam int IDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    sjrg_pkg::sjrg_cmd_t cmd;
    sjrg_pkg::sjrg_sts_t sts;
    logic [IDX_W-1:0]    idx;

    sjrg_ctrl #(.JOINTS(JOINTS), .IDX_W(IDX_W)) u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .sts       (sts),
        .cmd       (cmd),
        .idx       (idx)
    );

    sjrg_datapath #(.JOINTS(JOINTS), .IDX_W(IDX_W)) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .idx          (idx),
        .sts          (sts),
        .joint        (joint),
        .channel      (channel),
        .target_angle (target_angle),
        .pulse_min    (pulse_min),
        .pulse_max    (pulse_max),
        .duration_ms  (duration_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_channel  (out_channel),
        .pulse        (pulse),
        .move_done    (move_done),
        .last         (last)
    );

endmodule
`default_nettype wire

@@ hdl/sjrg_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sjrg_div
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sjrg_div
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [sjrg_pkg::DIV_N_W-1:0]  dividend,
    input  wire logic [sjrg_pkg::DIV_D_W-1:0]  divisor,
    output logic      [sjrg_pkg::DIV_N_W-1:0]  quotient,
    output logic                               done
);

    logic [sjrg_pkg::DIV_N_W-1:0] quo_reg, quo_next;
    logic [sjrg_pkg::DIV_D_W-1:0] rem_reg, rem_next;
    logic [sjrg_pkg::DIV_D_W-1:0] dvs_reg, dvs_next;
    logic [sjrg_pkg::DIV_C_W-1:0] cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [sjrg_pkg::DIV_D_W:0]   shifted;
    logic [sjrg_pkg::DIV_D_W:0]   diff;
    logic                         fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[sjrg_pkg::DIV_N_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        fits      = shifted >= {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = sjrg_pkg::DIV_STEPS;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[sjrg_pkg::DIV_N_W-2:0], fits};
            rem_next = fits ? diff[sjrg_pkg::DIV_D_W-1:0] : shifted[sjrg_pkg::DIV_D_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == sjrg_pkg::DIV_C_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule
`default_nettype wire

@@ hdl/sjrg_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sjrg_datapath
// joint tables, move timer, interpolation arithmetic and result register
// ----------------------------------------------------------------------------
module sjrg_datapath
#(
    parameter int JOINTS = 3,
    parameter int IDX_W  = 2
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sjrg_pkg::sjrg_cmd_t           cmd,
    input  wire logic [IDX_W-1:0]              idx,
    output sjrg_pkg::sjrg_sts_t                sts,
    input  wire logic [1:0]                    joint,
    input  wire logic [sjrg_pkg::CH_W-1:0]     channel,
    input  wire logic [sjrg_pkg::ANGLE_W-1:0]  target_angle,
    input  wire logic [sjrg_pkg::PULSE_W-1:0]  pulse_min,
    input  wire logic [sjrg_pkg::PULSE_W-1:0]  pulse_max,
    input  wire logic [sjrg_pkg::DUR_W-1:0]    duration_ms,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [sjrg_pkg::CH_W-1:0]     out_channel,
    output logic      [sjrg_pkg::PULSE_W-1:0]  pulse,
    output logic                               move_done,
    output logic                               last
);

    logic [sjrg_pkg::CH_W-1:0]    ch_reg    [JOINTS];
    logic [sjrg_pkg::ANGLE_W-1:0] tgt_reg   [JOINTS];
    logic [sjrg_pkg::PULSE_W-1:0] lo_reg    [JOINTS];
    logic [sjrg_pkg::PULSE_W-1:0] hi_reg    [JOINTS];
    logic [sjrg_pkg::ANGLE_W-1:0] start_reg [JOINTS];
    logic [sjrg_pkg::ANGLE_W-1:0] cur_reg   [JOINTS];
    logic [JOINTS-1:0]            chg_reg;
    logic [sjrg_pkg::DUR_W-1:0]   len_reg;
    logic [sjrg_pkg::DUR_W-1:0]   elapsed_reg;
    logic                         moving_reg;
    logic [sjrg_pkg::DIV_N_W-1:0] prod_reg;
    logic [sjrg_pkg::PULSE_W:0]   pq_reg;
    logic                         neg_reg;
    logic                         out_valid_reg;
    logic [sjrg_pkg::CH_W-1:0]    out_channel_reg;
    logic [sjrg_pkg::PULSE_W-1:0] pulse_reg;
    logic                         move_done_reg;
    logic                         last_reg;

    logic [sjrg_pkg::ANGLE_W-1:0] start_sel, tgt_sel, cur_sel;
    logic [sjrg_pkg::PULSE_W-1:0] lo_sel, hi_sel;
    logic [sjrg_pkg::ANGLE_W-1:0] angle_mag;
    logic [sjrg_pkg::PULSE_W-1:0] span_mag;
    logic [sjrg_pkg::ANGLE_W-1:0] pos_val;
    logic [36:0]                  recip_prod;
    logic signed [14:0]           pulse_raw;
    logic [sjrg_pkg::PULSE_W-1:0] pulse_sat;
    logic                         all_there;
    logic                         more_changed;
    logic                         div_start;
    logic [sjrg_pkg::DIV_N_W-1:0] div_q;
    logic                         div_done;

    always_comb
    begin
        start_sel = start_reg[idx];
        tgt_sel   = tgt_reg[idx];
        cur_sel   = cur_reg[idx];
        lo_sel    = lo_reg[idx];
        hi_sel    = hi_reg[idx];
        angle_mag = (tgt_sel >= start_sel) ? tgt_sel - start_sel : start_sel - tgt_sel;
        span_mag  = (hi_sel >= lo_sel) ? hi_sel - lo_sel : lo_sel - hi_sel;
        pos_val   = neg_reg ? start_sel - div_q[sjrg_pkg::ANGLE_W-1:0]
                            : start_sel + div_q[sjrg_pkg::ANGLE_W-1:0];
        // angle times span is below 2**20, so dropping two bits leaves a divide by 45
        recip_prod = 37'(prod_reg[19:2]) * 37'(sjrg_pkg::PULSE_RECIP);
        pulse_raw = neg_reg ? $signed({3'b000, lo_sel}) - $signed({2'b00, pq_reg})
                            : $signed({3'b000, lo_sel}) + $signed({2'b00, pq_reg});
        if (pulse_raw < 0)
            pulse_sat = '0;
        else if (pulse_raw > $signed({3'b000, sjrg_pkg::PULSE_TOP}))
            pulse_sat = sjrg_pkg::PULSE_TOP;
        else
            pulse_sat = pulse_raw[sjrg_pkg::PULSE_W-1:0];
        all_there    = 1'b1;
        more_changed = 1'b0;
        for (int j = 0; j < JOINTS; j++)
        begin
            if (cur_reg[j] != tgt_reg[j])
                all_there = 1'b0;
            if (j > int'(idx) && chg_reg[j])
                more_changed = 1'b1;
        end
    end

    assign div_start = cmd.pos_div;

    sjrg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (len_reg),
        .quotient (div_q),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < JOINTS; j++)
            begin
                ch_reg[j]    <= '0;
                tgt_reg[j]   <= '0;
                lo_reg[j]    <= '0;
                hi_reg[j]    <= '0;
                start_reg[j] <= '0;
                cur_reg[j]   <= sjrg_pkg::RESET_ANGLE;
            end
            chg_reg       <= '0;
            len_reg       <= '0;
            elapsed_reg   <= '0;
            moving_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int j = 0; j < JOINTS; j++)
            begin
                if (cmd.load && int'(joint) == j)
                begin
                    ch_reg[j]  <= channel;
                    tgt_reg[j] <= target_angle;
                    lo_reg[j]  <= pulse_min;
                    hi_reg[j]  <= pulse_max;
                end
                if (cmd.start)
                    start_reg[j] <= cur_reg[j];
            end
            if (cmd.start)
            begin
                len_reg     <= duration_ms;
                elapsed_reg <= '0;
                moving_reg  <= 1'b1;
            end
            if (cmd.tick && moving_reg && elapsed_reg != sjrg_pkg::ELAPSED_TOP)
                elapsed_reg <= elapsed_reg + 1'b1;
            if (cmd.pos_wb)
            begin
                chg_reg[idx] <= pos_val != cur_sel;
                cur_reg[idx] <= pos_val;
            end
            if (cmd.emit_done)
                moving_reg <= 1'b0;
            if (cmd.emit_pulse || cmd.emit_done)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pos_mul)
        begin
            prod_reg <= {8'd0, elapsed_reg} * {16'd0, angle_mag};
            neg_reg  <= tgt_sel < start_sel;
        end
        if (cmd.pul_mul)
        begin
            prod_reg <= {16'd0, cur_sel} * {12'd0, span_mag};
            neg_reg  <= hi_sel < lo_sel;
        end
        if (cmd.pul_div)
            pq_reg <= recip_prod[36:24];
        if (cmd.emit_pulse)
        begin
            out_channel_reg <= ch_reg[idx];
            pulse_reg       <= pulse_sat;
            move_done_reg   <= 1'b0;
            last_reg        <= !more_changed;
        end
        if (cmd.emit_done)
        begin
            out_channel_reg <= '0;
            pulse_reg       <= '0;
            move_done_reg   <= 1'b1;
            last_reg        <= 1'b1;
        end
    end

    always_comb
    begin
        sts.done_cond   = all_there || (elapsed_reg >= len_reg);
        sts.moving      = moving_reg;
        sts.div_done    = div_done;
        sts.sel_changed = chg_reg[idx];
        sts.sel_last    = !more_changed;
        sts.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign pulse       = pulse_reg;
    assign move_done   = move_done_reg;
    assign last        = last_reg;

    a_pos_between: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pos_wb |-> (neg_reg ? (pos_val >= tgt_sel && pos_val <= start_sel)
                                : (pos_val >= start_sel && pos_val <= tgt_sel)))
        else $error("interpolated angle outside start and target");

    a_pos_quot_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pos_wb |-> div_q[sjrg_pkg::DIV_N_W-1:sjrg_pkg::ANGLE_W] == '0)
        else $error("position quotient exceeds angle width");

    a_stop_by_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(moving_reg) |-> $past(cmd.emit_done))
        else $error("move stopped without a done item");

endmodule
`default_nettype wire

@@ hdl/sjrg_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sjrg_ctrl
// sequencer: decodes items, walks the joints through position and pulse
// ----------------------------------------------------------------------------
module sjrg_ctrl
#(
    parameter int JOINTS = 3,
    parameter int IDX_W  = 2
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           operation,
    input  wire sjrg_pkg::sjrg_sts_t  sts,
    output sjrg_pkg::sjrg_cmd_t       cmd,
    output logic      [IDX_W-1:0]     idx
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_DONE   = 4'd2;
    localparam logic [3:0] S_PMUL   = 4'd3;
    localparam logic [3:0] S_PSTART = 4'd4;
    localparam logic [3:0] S_PDIV   = 4'd5;
    localparam logic [3:0] S_PWB    = 4'd6;
    localparam logic [3:0] S_SCAN   = 4'd7;
    localparam logic [3:0] S_QMUL   = 4'd8;
    localparam logic [3:0] S_QSTART = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd11;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(JOINTS - 1);

    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (operation)
                        sjrg_pkg::OP_LOAD:
                            cmd.load = 1'b1;
                        sjrg_pkg::OP_START:
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_CHECK;
                        end
                        sjrg_pkg::OP_TICK:
                        begin
                            if (sts.moving)
                            begin
                                cmd.tick   = 1'b1;
                                state_next = S_CHECK;
                            end
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_CHECK:
            begin
                idx_next   = '0;
                state_next = sts.done_cond ? S_DONE : S_PMUL;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_PMUL:
            begin
                cmd.pos_mul = 1'b1;
                state_next  = S_PSTART;
            end
            S_PSTART:
            begin
                cmd.pos_div = 1'b1;
                state_next  = S_PDIV;
            end
            S_PDIV:
            begin
                if (sts.div_done)
                    state_next = S_PWB;
            end
            S_PWB:
            begin
                cmd.pos_wb = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_PMUL;
                end
            end
            S_SCAN:
            begin
                if (sts.sel_changed)
                    state_next = S_QMUL;
                else if (idx_reg == LAST_IDX)
                    state_next = S_IDLE;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_QMUL:
            begin
                cmd.pul_mul = 1'b1;
                state_next  = S_QSTART;
            end
            S_QSTART:
            begin
                cmd.pul_div = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_pulse = 1'b1;
                    if (idx_reg == LAST_IDX)
                        state_next = S_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign idx = idx_reg;

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_pulse || cmd.emit_done) |-> sts.out_free)
        else $error("result register overwritten");

    a_div_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pos_div |=> !sts.div_done)
        else $error("divider done seen right after start");

    a_done_cond_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_done |-> sts.done_cond)
        else $error("done item without end of move");

endmodule
`default_nettype wire

@@ test/tb_servo_joint_ramp_generator_unit.sv @@
// ----------------------------------------------------------------------------
// tb_servo_joint_ramp_generator_unit
// self-checking bench for the three-joint servo ramp: directed corner moves
// followed by random load/start/tick sequences, with random gaps on the input
// side and random stalls on the output side; every out item is compared
// field by field against an in-bench ramp predictor
// ----------------------------------------------------------------------------
module tb_servo_joint_ramp_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_NONE      = 2'd3;
    localparam int         JOINT_COUNT  = 3;
    localparam int         RANDOM_ITEMS = 100;
    localparam int         DRAIN_CYCLES = 400;
    localparam int         CYCLE_LIMIT  = 600000;
    localparam int         PULSE_CEIL   = 4095;
    localparam int         DEGREES_HALF = 180;
    localparam int         CH_W         = sjrg_pkg::CH_W;
    localparam int         ANGLE_W      = sjrg_pkg::ANGLE_W;
    localparam int         PULSE_W      = sjrg_pkg::PULSE_W;
    localparam int         DUR_W        = sjrg_pkg::DUR_W;

    typedef struct {
        logic [CH_W-1:0]    ch;
        logic [PULSE_W-1:0] pl;
        logic               done;
        logic               is_last;
    } pulse_rec_t;

    class ramp_scoreboard;
        logic [CH_W-1:0]    chan_of  [JOINT_COUNT];
        logic [ANGLE_W-1:0] goal_of  [JOINT_COUNT];
        logic [PULSE_W-1:0] low_of   [JOINT_COUNT];
        logic [PULSE_W-1:0] high_of  [JOINT_COUNT];
        logic [ANGLE_W-1:0] from_of  [JOINT_COUNT];
        logic [ANGLE_W-1:0] angle_of [JOINT_COUNT];
        logic [DUR_W-1:0]   span_ms;
        logic [DUR_W-1:0]   spent_ms;
        bit                 moving;
        pulse_rec_t         due_pulses[$];
        int                 errors;

        function new();
            for (int i = 0; i < JOINT_COUNT; i++)
            begin
                chan_of[i]  = '0;
                goal_of[i]  = '0;
                low_of[i]   = '0;
                high_of[i]  = '0;
                from_of[i]  = '0;
                angle_of[i] = 8'd90;
            end
            span_ms  = '0;
            spent_ms = '0;
            moving   = 1'b0;
            errors   = 0;
        endfunction

        function void step_ramp();
            bit         arrived;
            int         first;
            int         s;
            int         t;
            int         p;
            int         pl;
            pulse_rec_t rec;
            arrived = 1'b1;
            first   = due_pulses.size();
            for (int i = 0; i < JOINT_COUNT; i++)
                if (angle_of[i] != goal_of[i])
                    arrived = 1'b0;
            if (arrived || spent_ms >= span_ms)
            begin
                moving      = 1'b0;
                rec.ch      = '0;
                rec.pl      = '0;
                rec.done    = 1'b1;
                rec.is_last = 1'b0;
                due_pulses.push_back(rec);
            end
            else
            begin
                for (int i = 0; i < JOINT_COUNT; i++)
                begin
                    s = int'(from_of[i]);
                    t = int'(goal_of[i]);
                    p = s + (int'(spent_ms) * (t - s)) / int'(span_ms);
                    if (p != int'(angle_of[i]))
                    begin
                        angle_of[i] = p[ANGLE_W-1:0];
                        pl = p * (int'(high_of[i]) - int'(low_of[i])) / DEGREES_HALF
                             + int'(low_of[i]);
                        if (pl < 0)
                            pl = 0;
                        if (pl > PULSE_CEIL)
                            pl = PULSE_CEIL;
                        rec.ch      = chan_of[i];
                        rec.pl      = pl[PULSE_W-1:0];
                        rec.done    = 1'b0;
                        rec.is_last = 1'b0;
                        due_pulses.push_back(rec);
                    end
                end
            end
            if (due_pulses.size() > first)
                due_pulses[due_pulses.size()-1].is_last = 1'b1;
        endfunction

        function void note_item(logic [1:0] op, logic [1:0] j, logic [CH_W-1:0] ch,
                                logic [ANGLE_W-1:0] tgt, logic [PULSE_W-1:0] lo,
                                logic [PULSE_W-1:0] hi, logic [DUR_W-1:0] dur);
            if (op == sjrg_pkg::OP_LOAD)
            begin
                if (j < JOINT_COUNT)
                begin
                    chan_of[j] = ch;
                    goal_of[j] = tgt;
                    low_of[j]  = lo;
                    high_of[j] = hi;
                end
            end
            else if (op == sjrg_pkg::OP_START)
            begin
                for (int i = 0; i < JOINT_COUNT; i++)
                    from_of[i] = angle_of[i];
                span_ms  = dur;
                spent_ms = '0;
                moving   = 1'b1;
                step_ramp();
            end
            else if (op == sjrg_pkg::OP_TICK && moving)
            begin
                if (spent_ms != sjrg_pkg::ELAPSED_TOP)
                    spent_ms = spent_ms + 1'b1;
                step_ramp();
            end
        endfunction

        function void check_pulse(logic [CH_W-1:0] ch, logic [PULSE_W-1:0] pl,
                                  logic done, logic fin);
            pulse_rec_t want;
            if (due_pulses.size() == 0)
            begin
                errors++;
                $error("unexpected out item: out_channel %0d pulse %0d move_done %0b",
                       ch, pl, done);
                return;
            end
            want = due_pulses.pop_front();
            if (ch !== want.ch)
            begin
                errors++;
                $error("out_channel mismatch: expected %0d, actual %0d", want.ch, ch);
            end
            if (pl !== want.pl)
            begin
                errors++;
                $error("pulse mismatch: expected %0d, actual %0d", want.pl, pl);
            end
            if (done !== want.done)
            begin
                errors++;
                $error("move_done mismatch: expected %0b, actual %0b", want.done, done);
            end
            if (fin !== want.is_last)
            begin
                errors++;
                $error("last mismatch: expected %0b, actual %0b", want.is_last, fin);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           operation;
    logic [1:0]           joint;
    logic [CH_W-1:0]      channel;
    logic [ANGLE_W-1:0]   target_angle;
    logic [PULSE_W-1:0]   pulse_min;
    logic [PULSE_W-1:0]   pulse_max;
    logic [DUR_W-1:0]     duration_ms;
    logic                 out_valid;
    logic                 out_ready;
    logic [CH_W-1:0]      out_channel;
    logic [PULSE_W-1:0]   pulse;
    logic                 move_done;
    logic                 last;

    ramp_scoreboard sb = new();
    bit             steady = 1'b0;
    int             work_items = 0;
    int             cycle_count = 0;

    servo_joint_ramp_generator_unit #(.JOINTS(JOINT_COUNT)) u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .joint        (joint),
        .channel      (channel),
        .target_angle (target_angle),
        .pulse_min    (pulse_min),
        .pulse_max    (pulse_max),
        .duration_ms  (duration_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_channel  (out_channel),
        .pulse        (pulse),
        .move_done    (move_done),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= steady || ($urandom_range(0, 99) >= 16);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_pulse(out_channel, pulse, move_done, last);

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk) cycle_count++;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_item(input logic [1:0] op, input logic [1:0] j,
                             input logic [CH_W-1:0] ch, input logic [ANGLE_W-1:0] tgt,
                             input logic [PULSE_W-1:0] lo, input logic [PULSE_W-1:0] hi,
                             input logic [DUR_W-1:0] dur);
        while (!steady && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        joint        <= j;
        channel      <= ch;
        target_angle <= tgt;
        pulse_min    <= lo;
        pulse_max    <= hi;
        duration_ms  <= dur;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if ((op == sjrg_pkg::OP_LOAD && j < JOINT_COUNT) || op == sjrg_pkg::OP_START ||
            (op == sjrg_pkg::OP_TICK && sb.moving))
            work_items++;
        sb.note_item(op, j, ch, tgt, lo, hi, dur);
        @(negedge clk);
    endtask

    task automatic load_joint(input logic [1:0] j, input logic [CH_W-1:0] ch,
                              input logic [ANGLE_W-1:0] tgt, input logic [PULSE_W-1:0] lo,
                              input logic [PULSE_W-1:0] hi);
        send_item(sjrg_pkg::OP_LOAD, j, ch, tgt, lo, hi, DUR_W'($urandom));
    endtask

    task automatic start_move(input logic [DUR_W-1:0] dur);
        send_item(sjrg_pkg::OP_START, 2'($urandom), CH_W'($urandom), ANGLE_W'($urandom),
                  PULSE_W'($urandom), PULSE_W'($urandom), dur);
    endtask

    task automatic tick_ms();
        send_item(sjrg_pkg::OP_TICK, 2'($urandom), CH_W'($urandom), ANGLE_W'($urandom),
                  PULSE_W'($urandom), PULSE_W'($urandom), DUR_W'($urandom));
    endtask

    task automatic random_load();
        logic [1:0]         j;
        logic [ANGLE_W-1:0] tgt;
        j   = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, JOINT_COUNT - 1));
        tgt = ($urandom_range(0, 3) == 0) ? ANGLE_W'($urandom)
                                          : ANGLE_W'($urandom_range(0, 180));
        load_joint(j, CH_W'($urandom), tgt, PULSE_W'($urandom), PULSE_W'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.due_pulses.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int r;
        int guard;
        int base;
        logic [DUR_W-1:0] dur;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = sjrg_pkg::OP_LOAD;
        joint        = '0;
        channel      = '0;
        target_angle = '0;
        pulse_min    = '0;
        pulse_max    = '0;
        duration_ms  = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // idle tick, unused op, out-of-range joint
        tick_ms();
        send_item(OP_NONE, 2'($urandom), CH_W'($urandom), ANGLE_W'($urandom),
                  PULSE_W'($urandom), PULSE_W'($urandom), DUR_W'($urandom));
        load_joint(2'd3, 4'd15, 8'd255, 12'd4095, 12'd4095);
        // all joints already at goal
        load_joint(2'd0, 4'd0, 8'd90, 12'd0, 12'd4095);
        load_joint(2'd1, 4'd15, 8'd90, 12'd4095, 12'd0);
        load_joint(2'd2, 4'd7, 8'd90, 12'd100, 12'd200);
        start_move(16'd10);
        // zero duration, then a move that runs out short of goal
        load_joint(2'd0, 4'd0, 8'd0, 12'd0, 12'd4095);
        load_joint(2'd1, 4'd15, 8'd180, 12'd4095, 12'd0);
        start_move(16'd0);
        start_move(16'd4);
        repeat (4) tick_ms();
        wait_drained();
        // goals beyond 180, pulse saturation, restarts, load mid-move
        load_joint(2'd0, 4'd3, 8'd255, 12'd1000, 12'd4095);
        load_joint(2'd1, 4'd12, 8'd255, 12'd4095, 12'd0);
        start_move(16'hFFFF);
        repeat (2) tick_ms();
        start_move(16'd2);
        tick_ms();
        load_joint(2'd2, 4'd5, 8'd0, 12'd0, 12'd4095);
        start_move(16'd2);
        repeat (2) tick_ms();

        base = work_items;
        while (work_items - base < RANDOM_ITEMS)
        begin
            steady = (work_items - base >= 50) && (work_items - base < 80);
            repeat ($urandom_range(1, 4)) random_load();
            r = $urandom_range(0, 99);
            if (r < 10)
                dur = '0;
            else if (r < 75)
                dur = DUR_W'($urandom_range(1, 12));
            else if (r < 92)
                dur = DUR_W'($urandom_range(13, 24));
            else
                dur = DUR_W'($urandom);
            start_move(dur);
            guard = 0;
            while (sb.moving && guard < 30)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    send_item(OP_NONE, 2'($urandom), CH_W'($urandom), ANGLE_W'($urandom),
                              PULSE_W'($urandom), PULSE_W'($urandom), DUR_W'($urandom));
                else if (r < 8)
                    random_load();
                else if (r < 10)
                    start_move(DUR_W'($urandom_range(1, 12)));
                else
                    tick_ms();
                guard++;
            end
            if (sb.moving)
                start_move('0);
            if ($urandom_range(0, 9) == 0)
                tick_ms();
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end
        steady = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.due_pulses.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/sjrg_pkg.sv
hdl/sjrg_div.sv
hdl/sjrg_datapath.sv
hdl/sjrg_ctrl.sv
hdl/servo_joint_ramp_generator_unit.sv
test/tb_servo_joint_ramp_generator_unit.sv
